[sv/ofpf_pkg.sv]
// Shared constants and types for the odd parity character framer.
`timescale 1ns / 1ps
`default_nettype none
package ofpf_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 7;
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    // one extra address bit selects the bank (double buffer)
    localparam int ADDR_W      = SLOT_W + 1;
    localparam int CNT_W       = 7;
    localparam int FRAME_HDR   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd22;

    // func codes carried on tuser
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // store write from the front end
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // one frame to send: data count and bank holding the data
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             bank;
    } frame_cmd_t;

    // back end status
    typedef struct packed {
        logic busy;
        logic bank;
        logic done;
    } back_status_t;

endpackage
`default_nettype wire

[sv/odd_parity_char_framer.sv]
// Top level of the odd parity character framer.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tdata: char_code; tuser: func
//  m_      | out | m_tvalid/m_tready  | tdata: first_byte, second_byte, second_valid; tlast
//  cfg_    | in  | cfg_we             | cfg_wdata: sync_char
//
// A data character is taken every cycle while s_tready is high and written to one bank
// of the byte store. A frame of n data bytes is sent as n+3 bytes, one byte a cycle from
// the store's single read port unless the output stalls, up to two bytes per output
// request, with the sequencer idle between frames. Two banks let a new frame fill while
// the previous one drains; s_tready drops while two frames are queued or being sent.
// Synchronous active-low reset clears the fill count, queue and sequencer, not the store.
`timescale 1ns / 1ps
`default_nettype none
module odd_parity_char_framer #(
    parameter int FRAME_DATA = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [6:0] char_code, [7] zero
    input  wire  [0:0]  s_tuser,    // [0] func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // [7:0] first_byte, [15:8] second_byte,
                                    // [16] second_valid, [23:17] zero
    output logic        m_tlast,    // last_of_frame
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata   // sync_char
);

    logic [ofpf_pkg::BYTE_W-1:0] sync_reg;
    ofpf_pkg::wr_req_t           wr;
    ofpf_pkg::frame_cmd_t        cmd, q_head;
    ofpf_pkg::back_status_t      back_stat;
    logic                        cmd_push, q_pop, q_empty;
    logic [ofpf_pkg::BYTE_W-1:0] m_first, m_second;
    logic                        m_second_valid;

    // sync character register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            sync_reg <= ofpf_pkg::SYNC_RESET;
        else if (cfg_we)
            sync_reg <= cfg_wdata;
    end

    ofpf_front #(
        .FRAME_DATA (FRAME_DATA)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser[0]),
        .s_code    (s_tdata[ofpf_pkg::CODE_W-1:0]),
        .back_stat (back_stat),
        .wr        (wr),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    ofpf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    ofpf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sync_char      (sync_reg),
        .wr             (wr),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .status         (back_stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_first        (m_first),
        .m_second       (m_second),
        .m_second_valid (m_second_valid),
        .m_last         (m_tlast)
    );

    assign m_tdata = {7'd0, m_second_valid, m_second, m_first};

`ifndef ASSERT_OFF
    // front must never write the bank being sent
    a_bank_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.en && back_stat.busy && (wr.addr[ofpf_pkg::ADDR_W-1] == back_stat.bank)))
        else $error("store write hits the bank being sent");

    // finishing a frame loads its closing request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.done |=> (m_tvalid && m_tlast))
        else $error("frame end without closing request");

    // a lone trailing byte carries a zero partner
    a_second_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:8] == 8'd0))
        else $error("second byte not zero when unused");
`endif

endmodule
`default_nettype wire

[sv/ofpf_front.sv]
// Front end: adds parity, writes the store and issues frame commands.
`timescale 1ns / 1ps
`default_nettype none
module ofpf_front #(
    parameter int FRAME_DATA = 64
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire                                   s_func,
    input  wire  [ofpf_pkg::CODE_W-1:0]           s_code,
    input  ofpf_pkg::back_status_t                back_stat,
    output ofpf_pkg::wr_req_t                     wr,
    output logic                                  cmd_push,
    output ofpf_pkg::frame_cmd_t                  cmd
);

    logic [ofpf_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic                        bank_reg, bank_next;
    logic [ofpf_pkg::QCNT_W-1:0] outst_reg, outst_next;
    logic [ofpf_pkg::CNT_W-1:0]  fill_inc;
    logic                        accept;

    // stall only while both banks are tied up by frames
    assign s_tready = (outst_reg < ofpf_pkg::QCNT_W'(ofpf_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + ofpf_pkg::CNT_W'(1);

    // classify the request
    always_comb begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        wr        = '0;
        cmd_push  = 1'b0;
        cmd.count = fill_reg;
        cmd.bank  = bank_reg;
        if (accept) begin
            case (s_func)
                ofpf_pkg::FUNC_DATA: begin
                    wr.en   = 1'b1;
                    wr.addr = {bank_reg, fill_reg[ofpf_pkg::SLOT_W-1:0]};
                    wr.data = {~^s_code, s_code};
                    if (fill_inc == ofpf_pkg::CNT_W'(FRAME_DATA)) begin
                        cmd_push  = 1'b1;
                        cmd.count = fill_inc;
                        fill_next = '0;
                        bank_next = ~bank_reg;
                    end else begin
                        fill_next = fill_inc;
                    end
                end
                ofpf_pkg::FUNC_FLUSH: begin
                    // empty flush sends nothing
                    if (fill_reg != '0) begin
                        cmd_push  = 1'b1;
                        fill_next = '0;
                        bank_next = ~bank_reg;
                    end
                end
                default: begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    // frames queued or in flight
    always_comb begin
        case ({cmd_push, back_stat.done})
            2'b10:   outst_next = outst_reg + ofpf_pkg::QCNT_W'(1);
            2'b01:   outst_next = outst_reg - ofpf_pkg::QCNT_W'(1);
            default: outst_next = outst_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
            outst_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
            outst_reg <= outst_next;
        end
    end

endmodule
`default_nettype wire

[sv/ofpf_queue.sv]
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module ofpf_queue (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      push,
    input  ofpf_pkg::frame_cmd_t     push_cmd,
    input  wire                      pop,
    output logic                     empty,
    output ofpf_pkg::frame_cmd_t     head
);

    ofpf_pkg::frame_cmd_t           entry_reg [ofpf_pkg::QUEUE_DEPTH];
    logic [ofpf_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ofpf_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + ofpf_pkg::QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - ofpf_pkg::QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    // pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + ofpf_pkg::QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + ofpf_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

[sv/ofpf_back.sv]
// Back end: banked byte store and frame sequencer, up to two bytes per output request.
`timescale 1ns / 1ps
`default_nettype none
module ofpf_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [ofpf_pkg::BYTE_W-1:0]      sync_char,
    input  ofpf_pkg::wr_req_t                wr,
    input  wire                              q_empty,
    input  ofpf_pkg::frame_cmd_t             q_head,
    output logic                             q_pop,
    output ofpf_pkg::back_status_t           status,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ofpf_pkg::BYTE_W-1:0]      m_first,
    output logic [ofpf_pkg::BYTE_W-1:0]      m_second,
    output logic                             m_second_valid,
    output logic                             m_last
);

    localparam int MEM_DEPTH = 2 * ofpf_pkg::STORE_DEPTH;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic [ofpf_pkg::CNT_W-1:0]      pos_reg, pos_next;
    logic [ofpf_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            bank_reg, bank_next;
    logic                            half_reg;
    logic [ofpf_pkg::BYTE_W-1:0]     hold_reg;
    logic                            valid_reg;
    logic [ofpf_pkg::BYTE_W-1:0]     first_reg, second_reg;
    logic                            sv_reg, last_reg;

    logic [ofpf_pkg::BYTE_W-1:0]     mem [MEM_DEPTH];
    logic [ofpf_pkg::BYTE_W-1:0]     rdata_reg;
    logic [ofpf_pkg::ADDR_W-1:0]     rd_addr;
    logic [ofpf_pkg::CNT_W-1:0]      rd_off;

    logic                            start, adv, is_last, need_load, out_free, load;
    logic [ofpf_pkg::BYTE_W-1:0]     cur_byte;

    // current frame byte: sync, sync, length, then stored data
    always_comb begin
        if (pos_reg < ofpf_pkg::CNT_W'(2))
            cur_byte = sync_char;
        else if (pos_reg == ofpf_pkg::CNT_W'(2))
            cur_byte = ofpf_pkg::BYTE_W'(count_reg);
        else
            cur_byte = rdata_reg;
    end

    assign start     = (state_reg == ST_IDLE) && !q_empty;
    assign is_last   = (pos_reg == count_reg + ofpf_pkg::CNT_W'(ofpf_pkg::FRAME_HDR - 1));
    assign need_load = half_reg || is_last;
    assign out_free  = !valid_reg || m_tready;
    assign adv       = (state_reg == ST_RUN) && (out_free || !need_load);
    assign load      = adv && need_load;
    assign q_pop     = start;

    assign status.busy = (state_reg == ST_RUN);
    assign status.bank = bank_reg;
    assign status.done = adv && is_last;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        bank_next  = bank_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    pos_next   = '0;
                    count_next = q_head.count;
                    bank_next  = q_head.bank;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    pos_next = pos_reg + ofpf_pkg::CNT_W'(1);
                    if (is_last) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read one position ahead so the data lines up with pos_reg
    assign rd_off  = pos_next - ofpf_pkg::CNT_W'(ofpf_pkg::FRAME_HDR);
    assign rd_addr = {bank_next, rd_off[ofpf_pkg::SLOT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (wr.en) mem[wr.addr] <= wr.data;
        rdata_reg <= mem[rd_addr];
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start)
                half_reg <= 1'b0;
            else if (adv)
                half_reg <= ~half_reg;
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
        pos_reg   <= pos_next;
        count_reg <= count_next;
        bank_reg  <= bank_next;
        if (adv && !half_reg) hold_reg <= cur_byte;
        if (load) begin
            last_reg <= is_last;
            if (half_reg) begin
                first_reg  <= hold_reg;
                second_reg <= cur_byte;
                sv_reg     <= 1'b1;
            end else begin
                first_reg  <= cur_byte;
                second_reg <= '0;
                sv_reg     <= 1'b0;
            end
        end
    end

    assign m_tvalid       = valid_reg;
    assign m_first        = first_reg;
    assign m_second       = second_reg;
    assign m_second_valid = sv_reg;
    assign m_last         = last_reg;

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the odd parity character framer.
`timescale 1ns / 1ps
module testbench;
    import ofpf_pkg::*;

    localparam int FRAME_LEN    = 64;
    localparam int HALF_PERIOD  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 90;

    // one output request as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              second_valid;
        logic              last_of_frame;
    } frame_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [7:0]  s_tdata;     // [6:0] char_code, [7] zero
    logic [0:0]  s_tuser;     // [0] func
    wire         m_tvalid;
    logic        m_tready;
    wire  [23:0] m_tdata;     // [7:0] first_byte, [15:8] second_byte, [16] second_valid
    wire         m_tlast;     // last_of_frame
    logic        cfg_we;
    logic [7:0]  cfg_wdata;   // sync_char

    // predictor state
    logic [BYTE_W-1:0] held_bytes [0:STORE_DEPTH-1];
    int                held_count;
    logic [BYTE_W-1:0] sync_byte;
    frame_word_t       frame_words_due [$];

    int  mismatches;
    bit  idle_enable;
    int  ready_stall;

    odd_parity_char_framer #(
        .FRAME_DATA(FRAME_LEN)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // generous overall limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        if (mismatches < 50)
            $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // byte at a given position of the frame now being built
    function automatic logic [BYTE_W-1:0] frame_byte_at(input int pos);
        if (pos < 2)
            return sync_byte;
        if (pos == 2)
            return held_count[BYTE_W-1:0];
        return held_bytes[pos - FRAME_HDR];
    endfunction

    // queue the frame of held bytes, up to two bytes per request
    task automatic queue_frame_words();
        int total;
        int words;
        frame_word_t w;
        total = held_count + FRAME_HDR;
        words = (total + 1) / 2;
        for (int k = 0; k < words; k++) begin
            w.first_byte    = frame_byte_at(2 * k);
            w.second_valid  = (2 * k + 1) < total;
            w.second_byte   = w.second_valid ? frame_byte_at(2 * k + 1) : '0;
            w.last_of_frame = (k + 1 == words);
            frame_words_due.push_back(w);
        end
        held_count = 0;
    endtask

    // predictor: one accepted character or flush
    task automatic predict_frame_words(input logic func, input logic [CODE_W-1:0] code);
        if (func == FUNC_FLUSH) begin
            if (held_count != 0)
                queue_frame_words();
        end else begin
            // parity bit on top makes the number of ones odd
            held_bytes[held_count] = {~^code, code};
            held_count++;
            if (held_count >= FRAME_LEN)
                queue_frame_words();
        end
    endtask

    // sender: optional gap, then hold the request until accepted
    task automatic send_item(input logic func, input logic [CODE_W-1:0] code);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, code};
        do @(posedge aclk); while (!s_tready);
        predict_frame_words(func, code);
        @(negedge aclk);
    endtask

    task automatic send_run(input int count, input bit with_flush);
        for (int i = 0; i < count; i++)
            send_item(FUNC_DATA, CODE_W'($urandom_range(0, 127)));
        if (with_flush)
            send_item(FUNC_FLUSH, CODE_W'($urandom_range(0, 127)));
    endtask

    // stop sending, wait for every frame word, then let the block go quiet
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_sync(input logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sync_byte = value;
        @(negedge aclk);
    endtask

    // receiver back-pressure in bursts
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            m_tready    <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            m_tready    <= 1'b0;
            ready_stall <= $urandom_range(0, 14);
        end else begin
            m_tready    <= 1'b1;
        end
    end

    // compare each accepted request with the oldest expected word
    always @(posedge aclk) begin : check_words
        frame_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_words_due.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                want = frame_words_due.pop_front();
                if (m_tdata[7:0] !== want.first_byte)
                    report_mismatch("first_byte", 24'(m_tdata[7:0]), 24'(want.first_byte));
                if (m_tdata[15:8] !== want.second_byte)
                    report_mismatch("second_byte", 24'(m_tdata[15:8]),
                                    24'(want.second_byte));
                if (m_tdata[16] !== want.second_valid)
                    report_mismatch("second_valid", 24'(m_tdata[16]),
                                    24'(want.second_valid));
                if (m_tlast !== want.last_of_frame)
                    report_mismatch("last_of_frame", 24'(m_tlast), 24'(want.last_of_frame));
            end
        end
    end

    // parity extremes, odd and even frame lengths, flush on an empty buffer
    task automatic test_parity_and_flush();
        idle_enable = 1'b1;
        send_item(FUNC_DATA, 7'h00);
        send_item(FUNC_DATA, 7'h7F);
        send_item(FUNC_DATA, 7'h55);
        send_item(FUNC_DATA, 7'h2A);
        send_item(FUNC_DATA, 7'h01);
        send_item(FUNC_DATA, 7'h40);
        send_item(FUNC_FLUSH, 7'h7F);
        send_item(FUNC_FLUSH, 7'h00);
        send_item(FUNC_DATA, 7'h7E);
        send_item(FUNC_FLUSH, 7'h3C);
        settle_idle();
    endtask

    // sync byte at its extremes
    task automatic test_sync_extremes();
        write_sync(8'h00);
        send_run(2, 1'b1);
        settle_idle();
        write_sync(8'hFF);
        send_run(3, 1'b1);
        settle_idle();
        write_sync(SYNC_RESET);
    endtask

    // full frames and flushed partial frames, some stray flushes
    task automatic test_random_frames();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_enable = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) == 0) begin
                settle_idle();
                write_sync(BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) == 0)
                run_len = FRAME_LEN;
            else
                run_len = $urandom_range(1, FRAME_LEN - 1);
            send_run(run_len, run_len < FRAME_LEN);
            sent += run_len + (run_len < FRAME_LEN ? 1 : 0);
            if ($urandom_range(0, 5) == 0)
                send_item(FUNC_FLUSH, CODE_W'($urandom_range(0, 127)));
        end
        settle_idle();
    endtask

    // no idling: frames queue up in both banks
    task automatic test_back_to_back();
        idle_enable = 1'b0;
        send_run(FRAME_LEN, 1'b0);
        send_run(FRAME_LEN, 1'b0);
        send_run(17, 1'b1);
        settle_idle();
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_DATA;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        mismatches  = 0;
        idle_enable = 1'b0;
        ready_stall = 0;
        held_count  = 0;
        sync_byte   = SYNC_RESET;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_parity_and_flush();
        test_sync_extremes();
        test_random_frames();
        test_back_to_back();

        if (mismatches == 0 && frame_words_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
